@@ src/credit_flow_tx_queue_assert.svh @@
// Assertion macros for the credit flow transmit queue.
// Used by credit_flow_tx_queue.sv; expects clk and rst_n in scope.
`ifndef CREDIT_FLOW_TX_QUEUE_ASSERT_SVH
`define CREDIT_FLOW_TX_QUEUE_ASSERT_SVH

// same-cycle implication
`define CFTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cftq_pkg.sv @@
// Types and constants for the credit flow transmit queue.
// No dependencies; used by credit_flow_tx_queue.sv.
package cftq_pkg;

    localparam int HANDLE_BITS  = 16;
    localparam int CREDIT_BITS  = 16;
    localparam int LEN_BITS     = 7;
    localparam int CFG_BITS     = 7;
    localparam int ACTION_BITS  = 2;
    localparam int DEPTH_DFLT   = 64;

    localparam logic [ACTION_BITS-1:0] ACT_FEEDBACK = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SEND     = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_ARRIVE   = 2'd2;

    localparam logic REG_QUEUE_LIMIT  = 1'b0;
    localparam logic REG_RESUME_LEVEL = 1'b1;

    localparam logic [CFG_BITS-1:0]    LIMIT_RST  = 7'd64;
    localparam logic [CFG_BITS-1:0]    RESUME_RST = 7'd54;
    localparam logic [CREDIT_BITS-1:0] CREDIT_RST = 16'd1;

    typedef struct packed {
        logic                   sent_valid;
        logic [HANDLE_BITS-1:0] sent_payload;
        logic                   dropped;
        logic                   blocked;
        logic                   slow_down;
        logic                   speed_up;
        logic [LEN_BITS-1:0]    queue_length;
    } result_t;

endpackage

@@ src/credit_flow_tx_queue.sv @@
// Credit and congestion gated transmit FIFO with slow_down/speed_up throttle flags.
// Depends on cftq_pkg and credit_flow_tx_queue_assert.svh.
// The result of an accepted item is registered, via the skid register while the result port is stalled.
// Throughput: one item per cycle while item_stall is low; the queue state updates in one pass
//   and the head entry is prefetched from the packet memory into a register each cycle.
// A skid register lets one more item in while the result port is stalled.
// Reset: pointers, count, flags and config go to their reset values at once;
//   the packet memory is not cleared and needs no clearing pass.
`include "credit_flow_tx_queue_assert.svh"

module credit_flow_tx_queue #(
    parameter int QUEUE_DEPTH = cftq_pkg::DEPTH_DFLT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [cftq_pkg::ACTION_BITS-1:0] action,
    input  logic [cftq_pkg::HANDLE_BITS-1:0] payload,
    input  logic                             fb_congested,
    input  logic [cftq_pkg::CREDIT_BITS-1:0] fb_credit,
    // result channel
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             sent_valid,
    output logic [cftq_pkg::HANDLE_BITS-1:0] sent_payload,
    output logic                             dropped,
    output logic                             blocked,
    output logic                             slow_down,
    output logic                             speed_up,
    output logic [cftq_pkg::LEN_BITS-1:0]    queue_length,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [cftq_pkg::CFG_BITS-1:0]    cfg_data
);

    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > cftq_pkg::CFG_BITS) ? CW : cftq_pkg::CFG_BITS;
    localparam logic [PW-1:0]   PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(QUEUE_DEPTH);

    logic [cftq_pkg::HANDLE_BITS-1:0] mem [QUEUE_DEPTH];

    logic [PW-1:0]                    head_ptr_reg, head_ptr_next;
    logic [PW-1:0]                    tail_ptr_reg, tail_ptr_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [cftq_pkg::CREDIT_BITS-1:0] credit_reg, credit_next;
    logic                             congested_reg, congested_next;
    logic                             throttled_reg, throttled_next;
    logic [cftq_pkg::CFG_BITS-1:0]    limit_reg, resume_reg;
    logic [cftq_pkg::HANDLE_BITS-1:0] head_data_reg;

    cftq_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;

    logic            accept, push, pop, is_send, is_arrive, throttle_mid;
    logic [CMPW-1:0] lim, count_ext, count_next_ext;

    assign cfg_ready  = 1'b1;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;

    assign is_send   = (action == cftq_pkg::ACT_SEND);
    assign is_arrive = (action == cftq_pkg::ACT_ARRIVE);

    always_comb
    begin
        lim = (CMPW'(limit_reg) > DEPTH_CMP) ? DEPTH_CMP : CMPW'(limit_reg);
        count_ext = CMPW'(count_reg);

        pop  = accept && is_send && (credit_reg != '0) && !congested_reg && (count_reg != '0);
        push = accept && is_arrive && (count_ext < lim);

        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        count_next_ext = CMPW'(count_next);

        head_ptr_next = pop  ? ((head_ptr_reg == PTR_LAST) ? '0 : head_ptr_reg + 1'b1)
                             : head_ptr_reg;
        tail_ptr_next = push ? ((tail_ptr_reg == PTR_LAST) ? '0 : tail_ptr_reg + 1'b1)
                             : tail_ptr_reg;

        congested_next = congested_reg;
        credit_next    = credit_reg;
        if (accept && (action == cftq_pkg::ACT_FEEDBACK))
        begin
            congested_next = fb_congested;
            credit_next    = fb_credit;
        end
        else if (pop)
        begin
            credit_next = credit_reg - 1'b1;
        end

        res.sent_valid   = pop;
        res.sent_payload = pop ? head_data_reg : '0;
        res.dropped      = is_arrive && !(count_ext < lim);
        res.blocked      = is_send && ((credit_reg == '0) || congested_reg);
        res.slow_down    = (count_next_ext >= lim);
        throttle_mid     = throttled_reg || res.slow_down;
        res.speed_up     = throttle_mid && (count_next_ext <= CMPW'(resume_reg));
        res.queue_length = count_next_ext[cftq_pkg::LEN_BITS-1:0];

        throttled_next = accept ? (throttle_mid && !res.speed_up) : throttled_reg;
    end

    // packet memory; the head entry is read ahead, with a bypass for a push
    // into the slot that becomes the head
    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_ptr_reg] <= payload;
        if (push && (tail_ptr_reg == head_ptr_next))
            head_data_reg <= payload;
        else
            head_data_reg <= mem[head_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg  <= '0;
            tail_ptr_reg  <= '0;
            count_reg     <= '0;
            credit_reg    <= cftq_pkg::CREDIT_RST;
            congested_reg <= 1'b0;
            throttled_reg <= 1'b0;
            limit_reg     <= cftq_pkg::LIMIT_RST;
            resume_reg    <= cftq_pkg::RESUME_RST;
        end
        else
        begin
            head_ptr_reg  <= head_ptr_next;
            tail_ptr_reg  <= tail_ptr_next;
            count_reg     <= count_next;
            credit_reg    <= credit_next;
            congested_reg <= congested_next;
            throttled_reg <= throttled_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cftq_pkg::REG_QUEUE_LIMIT:  limit_reg  <= cfg_data;
                    cftq_pkg::REG_RESUME_LEVEL: resume_reg <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    // result register plus skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !res_stall)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
        begin
            skid_reg <= res;
        end
    end

    assign res_valid    = out_valid_reg;
    assign sent_valid   = out_reg.sent_valid;
    assign sent_payload = out_reg.sent_payload;
    assign dropped      = out_reg.dropped;
    assign blocked      = out_reg.blocked;
    assign slow_down    = out_reg.slow_down;
    assign speed_up     = out_reg.speed_up;
    assign queue_length = out_reg.queue_length;

    `CFTQ_ASSERT_NOW(a_count_in_range, 1'b1, CMPW'(count_reg) <= DEPTH_CMP, "queue count above depth")
    `CFTQ_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without result word")
    `CFTQ_ASSERT_NEXT(a_pop_uses_credit, pop, credit_reg == $past(credit_reg) - 1'b1, "pop did not spend one credit")
    `CFTQ_ASSERT_NEXT(a_skid_drains, skid_valid_reg && !res_stall, !skid_valid_reg, "skid word not moved up")

endmodule
